FILE: src/thermal_trip_point_tracker_top_defines.svh
// Assertion macros for the thermal trip point tracker checker.
// Included by tpt_checker.sv; no other dependencies.
`ifndef THERMAL_TRIP_POINT_TRACKER_TOP_DEFINES_SVH
`define THERMAL_TRIP_POINT_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define TPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked across reset
`define TPT_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tpt_pkg.sv
// Shared types and constants for the thermal trip point tracker.
// No dependencies.
`timescale 1ns / 1ps

package tpt_pkg;

  localparam int MAX_TRIP_POINTS_DEF = 16;
  localparam int TEMP_WIDTH_DEF      = 16;

  localparam int FIELD_W     = 16;
  localparam int ENTRY_W     = 4;
  localparam int POINT_W     = 4;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CNT_W-1:0]      COUNT_RESET = 5'd1;
  localparam logic [CFG_DATA_W-1:0] CRIT_RESET  = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_TEMP  = 2'd1;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_LOAD   = 2'd2
  } tpt_op_t;

  typedef struct packed {
    logic [POINT_W-1:0] trip_point;
    logic               throttle_cpus;
  } tpt_result_t;

endpackage

FILE: src/thermal_trip_point_tracker_top.sv
// Thermal trip point tracker.
// Input stream: in_tuser carries the operation (start, sample, load table
// entry); in_tdata carries temperature, entry index and the two thresholds.
// Output stream: one request per trip point change, or per critical entry
// (throttle_cpus set), or per start item. Load items give no output.
// Configuration: cfg_wr_en / cfg_index / cfg_wdata write trip_count (index 0)
// and critical_temperature (index 1); write only while the block is idle.
// Pipeline: a request is taken into the decision stage as both tables are
// read, is decided there, and passes on to the output register (out_tvalid).
// Throughput: one request per cycle while out_tready is high; each sample
// reads the rise table and the fall table once through their own read
// ports, and the next read address is forwarded from the decision stage.
// Reset: trip point 0, critical flag clear, trip_count 1, critical
// temperature all ones. Tables are not cleared and must be loaded first.
// Receiver stall: the output register holds its request; one more request
// is still taken into the decision stage, after which in_tready drops.
// Depends on tpt_pkg, tpt_mem, tpt_core.
`timescale 1ns / 1ps

module thermal_trip_point_tracker_top #(
  parameter int MAX_TRIP_POINTS = tpt_pkg::MAX_TRIP_POINTS_DEF,
  parameter int TEMP_WIDTH      = tpt_pkg::TEMP_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] temperature, [19:16] entry_index, [35:20] rise_threshold,
  // [51:36] fall_threshold, [55:52] zero
  input  logic [tpt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] operation
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [3:0] trip_point, [4] throttle_cpus, [7:5] zero
  output logic [tpt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [tpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AW    = $clog2(MAX_TRIP_POINTS);
  localparam int FW    = tpt_pkg::FIELD_W;
  localparam int CW    = (TEMP_WIDTH < FW) ? TEMP_WIDTH : FW;
  localparam int CNTW  = tpt_pkg::CNT_W;
  localparam int OUTW  = tpt_pkg::OUT_TDATA_W;

  logic [CNTW-1:0]             trip_count_r;
  logic [tpt_pkg::CFG_DATA_W-1:0] crit_temp_r;

  logic                  accept;
  logic [1:0]            op;
  logic [TEMP_WIDTH-1:0] temp;
  logic [TEMP_WIDTH-1:0] rise_in;
  logic [TEMP_WIDTH-1:0] fall_in;
  logic [tpt_pkg::ENTRY_W-1:0] entry_idx;
  logic                  load_we;
  logic [AW-1:0]         cur_nxt;
  logic [AW-1:0]         top;
  logic [CNTW-1:0]       cnt_eff;
  logic [TEMP_WIDTH-1:0] rd_rise;
  logic [TEMP_WIDTH-1:0] rd_fall;
  logic [TEMP_WIDTH-1:0] crit_temp;
  logic                  core_ready;
  tpt_pkg::tpt_result_t  result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_count_r <= tpt_pkg::COUNT_RESET;
      crit_temp_r  <= tpt_pkg::CRIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tpt_pkg::CFG_TRIP_COUNT: trip_count_r <= cfg_wdata[CNTW-1:0];
        tpt_pkg::CFG_CRIT_TEMP:  crit_temp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = core_ready;
  assign accept    = in_tvalid && core_ready;
  assign op        = in_tuser;
  assign temp      = TEMP_WIDTH'(in_tdata[CW-1:0]);
  assign entry_idx = in_tdata[FW +: tpt_pkg::ENTRY_W];
  assign rise_in   = TEMP_WIDTH'(in_tdata[20 +: CW]);
  assign fall_in   = TEMP_WIDTH'(in_tdata[36 +: CW]);
  assign crit_temp = TEMP_WIDTH'(crit_temp_r[CW-1:0]);

  assign load_we = accept && (op == tpt_pkg::OP_LOAD)
                   && (32'(entry_idx) < 32'(MAX_TRIP_POINTS));

  always_comb begin
    cnt_eff = (trip_count_r == '0) ? CNTW'(1) : trip_count_r;
    if (32'(cnt_eff) > 32'(MAX_TRIP_POINTS)) begin
      top = AW'(MAX_TRIP_POINTS - 1);
    end else begin
      top = AW'(cnt_eff - CNTW'(1));
    end
  end

  tpt_mem #(
    .DEPTH (MAX_TRIP_POINTS),
    .AW    (AW),
    .DW    (TEMP_WIDTH)
  ) u_mem (
    .clk          (clk),
    .wr_en        (load_we),
    .wr_addr      (AW'(entry_idx)),
    .wr_rise      (rise_in),
    .wr_fall      (fall_in),
    .rd_en        (accept),
    .rd_addr_rise (cur_nxt + AW'(1)),
    .rd_addr_fall (cur_nxt),
    .rd_rise      (rd_rise),
    .rd_fall      (rd_fall)
  );

  tpt_core #(
    .MAX_TRIP_POINTS (MAX_TRIP_POINTS),
    .TEMP_WIDTH      (TEMP_WIDTH),
    .AW              (AW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (accept),
    .in_op      (op),
    .in_temp    (temp),
    .rd_rise    (rd_rise),
    .rd_fall    (rd_fall),
    .top        (top),
    .crit_temp  (crit_temp),
    .out_ready  (out_tready),
    .in_ready   (core_ready),
    .cur_nxt    (cur_nxt),
    .out_valid  (out_tvalid),
    .out_result (result)
  );

  assign out_tdata = OUTW'({result.throttle_cpus, result.trip_point});

endmodule

FILE: src/tpt_mem.sv
// Rise and fall threshold tables: one write port, one registered read port each.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module tpt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_rise,
  input  logic [DW-1:0] wr_fall,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_rise,
  input  logic [AW-1:0] rd_addr_fall,
  output logic [DW-1:0] rd_rise,
  output logic [DW-1:0] rd_fall
);

  logic [DW-1:0] rise_mem [DEPTH];
  logic [DW-1:0] fall_mem [DEPTH];
  logic [DW-1:0] rd_rise_r;
  logic [DW-1:0] rd_fall_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rise_mem[wr_addr] <= wr_rise;
      fall_mem[wr_addr] <= wr_fall;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rise_r <= rise_mem[rd_addr_rise];
      rd_fall_r <= fall_mem[rd_addr_fall];
    end
  end

  assign rd_rise = rd_rise_r;
  assign rd_fall = rd_fall_r;

endmodule

FILE: src/tpt_core.sv
// Decision stage: compares a request against the table words read for it,
// updates the trip point and critical flag, and holds the result register.
// Depends on tpt_pkg.
`timescale 1ns / 1ps

module tpt_core #(
  parameter int MAX_TRIP_POINTS = tpt_pkg::MAX_TRIP_POINTS_DEF,
  parameter int TEMP_WIDTH      = tpt_pkg::TEMP_WIDTH_DEF,
  parameter int AW              = $clog2(MAX_TRIP_POINTS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  logic [1:0]            in_op,
  input  logic [TEMP_WIDTH-1:0] in_temp,
  input  logic [TEMP_WIDTH-1:0] rd_rise,
  input  logic [TEMP_WIDTH-1:0] rd_fall,
  input  logic [AW-1:0]         top,
  input  logic [TEMP_WIDTH-1:0] crit_temp,
  input  logic                  out_ready,
  output logic                  in_ready,
  output logic [AW-1:0]         cur_nxt,
  output logic                  out_valid,
  output tpt_pkg::tpt_result_t  out_result
);

  localparam int PW = tpt_pkg::POINT_W;

  logic                  s1_v_r;
  logic [1:0]            s1_op_r;
  logic [TEMP_WIDTH-1:0] s1_temp_r;
  logic [AW-1:0]         cur_r;
  logic                  crit_r;
  logic                  out_v_r;
  tpt_pkg::tpt_result_t  out_res_r;

  logic          s1_go;
  logic          commit;
  logic          up;
  logic          down;
  logic          crit_hit;
  logic          res_v;
  logic          throttle;
  logic [AW-1:0] cur_calc;
  logic          crit_calc;

  assign s1_go    = !out_v_r || out_ready;
  assign commit   = s1_v_r && s1_go;
  assign in_ready = !s1_v_r || s1_go;

  assign up       = (cur_r < top) && (s1_temp_r >= rd_rise);
  assign down     = (cur_r != '0) && (s1_temp_r < rd_fall);
  assign crit_hit = (cur_r == top) && !crit_r && (s1_temp_r >= crit_temp);

  always_comb begin
    cur_calc  = cur_r;
    crit_calc = crit_r;
    res_v     = 1'b0;
    throttle  = 1'b0;
    unique case (s1_op_r)
      tpt_pkg::OP_START: begin
        cur_calc  = '0;
        crit_calc = 1'b0;
        res_v     = 1'b1;
      end
      tpt_pkg::OP_SAMPLE: begin
        if (up) begin
          cur_calc = cur_r + AW'(1);
          res_v    = 1'b1;
        end else if (down) begin
          if (cur_r == top) begin
            crit_calc = 1'b0;
          end
          cur_calc = cur_r - AW'(1);
          res_v    = 1'b1;
        end else if (crit_hit) begin
          crit_calc = 1'b1;
          throttle  = 1'b1;
          res_v     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cur_nxt = commit ? cur_calc : cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (commit) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r   <= in_op;
      s1_temp_r <= in_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      crit_r <= 1'b0;
    end else if (commit) begin
      cur_r  <= cur_calc;
      crit_r <= crit_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (commit && res_v) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && res_v) begin
      out_res_r.trip_point    <= PW'(cur_calc);
      out_res_r.throttle_cpus <= throttle;
    end
  end

  assign out_valid  = out_v_r;
  assign out_result = out_res_r;

endmodule

FILE: src/tpt_checker.sv
// Port-level checks for the thermal trip point tracker, bound to the top.
// Depends on tpt_pkg and thermal_trip_point_tracker_top_defines.svh.
`timescale 1ns / 1ps
`include "thermal_trip_point_tracker_top_defines.svh"

module tpt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tpt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `TPT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output request changed while stalled")
  `TPT_ASSERT_IMPL(a_ready_when_empty, !out_tvalid, in_tready, "input stalled with empty output register")
  `TPT_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid && in_tready, "not idle after reset")

endmodule

bind thermal_trip_point_tracker_top tpt_checker u_tpt_checker (.*);
